// ===== hw/rtl/qtpm_pkg.sv =====
package qtpm_pkg;

  localparam int MotorCount = 4;

  typedef enum logic [2:0] {
    REG_REF_TILT_X = 3'd0,
    REG_REF_TILT_Y = 3'd1,
    REG_GAIN_P     = 3'd2,
    REG_GAIN_I     = 3'd3,
    REG_GAIN_D     = 3'd4,
    REG_LOSS_LIMIT = 3'd5,
    REG_DECAY_STEP = 3'd6
  } cfg_reg_e;

  typedef logic signed [13:0] err_t;
  typedef logic signed [14:0] deriv_t;
  typedef logic signed [15:0] leak_t;
  typedef logic signed [9:0]  throttle_t;

  localparam logic signed [12:0] RefTiltReset   = 13'sd0;
  localparam logic [15:0]        GainPReset     = 16'd4608;
  localparam logic [15:0]        GainIReset     = 16'd230;
  localparam logic [15:0]        GainDReset     = 16'd512;
  localparam logic [15:0]        LossLimitReset = 16'd1000;
  localparam logic [7:0]         DecayStepReset = 8'd10;

  localparam throttle_t          ThrottleReset  = 10'sd15;
  localparam logic signed [11:0] ThrottleFloor  = -12'sd512;
  localparam logic signed [19:0] DriveMax       = 20'sd180;

  // ceil(2^17 / 3): exact floor(m / 3) for m up to 2^16
  localparam logic [15:0] Recip3 = 16'd43691;

  // set bit = that motor takes the axis term negated
  localparam logic [MotorCount-1:0] SignXNeg = 4'b1001;
  localparam logic [MotorCount-1:0] SignYNeg = 4'b1100;

endpackage

// ===== hw/rtl/quad_tilt_pid_mixer.sv =====
// Tilt PID and X-frame motor mixer. Each input word is one control tick and
// yields exactly one output word with the four motor drives (0..180). The
// block is a five-register pipeline (input register, error/integrator stage,
// gain product stage, axis sum stage, output register) and takes one word
// per cycle while the output is not held. Integrator, last error, base
// throttles and the loss counter are all updated in the second stage, so
// back-to-back ticks see each other's state. Each stage stalls only when it
// is full and its successor is held, so input is still taken while a
// finished word waits at the output, until the stages behind it fill up.
// Configuration writes take effect at once and are always ready.
module quad_tilt_pid_mixer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [12:0] tilt_x_i,
  input  logic signed [12:0] tilt_y_i,
  input  logic               cmd_valid_i,
  input  logic [7:0]         cmd_motor_a_i,
  input  logic [7:0]         cmd_motor_b_i,
  input  logic [7:0]         cmd_motor_c_i,
  input  logic [7:0]         cmd_motor_d_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         drive_a_o,
  output logic [7:0]         drive_b_o,
  output logic [7:0]         drive_c_o,
  output logic [7:0]         drive_d_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int NM = qtpm_pkg::MotorCount;

  // ---------------- configuration ----------------
  logic signed [12:0] ref_x_q, ref_y_q;
  logic [15:0]        gain_p_q, gain_i_q, gain_d_q, loss_limit_q;
  logic [7:0]         decay_step_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_x_q      <= qtpm_pkg::RefTiltReset;
      ref_y_q      <= qtpm_pkg::RefTiltReset;
      gain_p_q     <= qtpm_pkg::GainPReset;
      gain_i_q     <= qtpm_pkg::GainIReset;
      gain_d_q     <= qtpm_pkg::GainDReset;
      loss_limit_q <= qtpm_pkg::LossLimitReset;
      decay_step_q <= qtpm_pkg::DecayStepReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        qtpm_pkg::REG_REF_TILT_X: ref_x_q      <= $signed(cfg_data_i[12:0]);
        qtpm_pkg::REG_REF_TILT_Y: ref_y_q      <= $signed(cfg_data_i[12:0]);
        qtpm_pkg::REG_GAIN_P:     gain_p_q     <= cfg_data_i;
        qtpm_pkg::REG_GAIN_I:     gain_i_q     <= cfg_data_i;
        qtpm_pkg::REG_GAIN_D:     gain_d_q     <= cfg_data_i;
        qtpm_pkg::REG_LOSS_LIMIT: loss_limit_q <= cfg_data_i;
        qtpm_pkg::REG_DECAY_STEP: decay_step_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage handshake ----------------
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  logic s1_en, s2_en, s3_en, s4_en, out_en;

  assign out_en     = !out_v_q || out_ready_i;
  assign s4_en      = !s4_v_q  || out_en;
  assign s3_en      = !s3_v_q  || s4_en;
  assign s2_en      = !s2_v_q  || s3_en;
  assign s1_en      = !s1_v_q  || s2_en;
  assign in_ready_o = s1_en;
  assign out_valid_o = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_en)  s1_v_q  <= in_valid_i;
      if (s2_en)  s2_v_q  <= s1_v_q;
      if (s3_en)  s3_v_q  <= s2_v_q;
      if (s4_en)  s4_v_q  <= s3_v_q;
      if (out_en) out_v_q <= s4_v_q;
    end
  end

  // ---------------- stage 1: input register ----------------
  logic signed [12:0] s1_tilt_x_q, s1_tilt_y_q;
  logic               s1_cmd_q;
  logic [7:0]         s1_motor_q [NM];

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      s1_tilt_x_q   <= tilt_x_i;
      s1_tilt_y_q   <= tilt_y_i;
      s1_cmd_q      <= cmd_valid_i;
      s1_motor_q[0] <= cmd_motor_a_i;
      s1_motor_q[1] <= cmd_motor_b_i;
      s1_motor_q[2] <= cmd_motor_c_i;
      s1_motor_q[3] <= cmd_motor_d_i;
    end
  end

  // ---------------- stage 2: errors, integrator, throttle state ----------------
  // trunc0(2*leak/3) + err, saturated to 16 bits
  function automatic qtpm_pkg::leak_t leak_next(qtpm_pkg::leak_t leak, qtpm_pkg::err_t err);
    logic signed [16:0] dbl;
    logic [16:0]        mag;
    logic [32:0]        prod;
    logic signed [16:0] quo;
    logic signed [17:0] sum;
    qtpm_pkg::leak_t    res;
    dbl  = {leak, 1'b0};
    mag  = dbl[16] ? $unsigned(-dbl) : $unsigned(dbl);
    prod = 33'(mag) * 33'(qtpm_pkg::Recip3);
    quo  = dbl[16] ? -$signed({1'b0, prod[32:17]}) : $signed({1'b0, prod[32:17]});
    sum  = 18'(quo) + 18'(err);
    if (sum > 18'sd32767) begin
      res = 16'sd32767;
    end else if (sum < -18'sd32768) begin
      res = -16'sd32768;
    end else begin
      res = sum[15:0];
    end
    return res;
  endfunction

  qtpm_pkg::leak_t     leak_x_q, leak_y_q, leak_x_d, leak_y_d;
  qtpm_pkg::err_t      prev_x_q, prev_y_q, err_x, err_y;
  qtpm_pkg::throttle_t base_q [NM];
  qtpm_pkg::throttle_t base_d [NM];
  logic [15:0]         quiet_q, quiet_d;

  logic signed [11:0] tsum, tavg, tnew;

  assign err_x    = 14'(s1_tilt_x_q) - 14'(ref_x_q);
  assign err_y    = 14'(s1_tilt_y_q) - 14'(ref_y_q);
  assign leak_x_d = leak_next(leak_x_q, err_x);
  assign leak_y_d = leak_next(leak_y_q, err_y);

  always_comb begin
    tsum = 12'(base_q[0]) + 12'(base_q[1]) + 12'(base_q[2]) + 12'(base_q[3]);
    tavg = (tsum + (tsum[11] ? 12'sd3 : 12'sd0)) >>> 2;
    tnew = tavg - $signed({4'b0, decay_step_q});
    if (tnew < qtpm_pkg::ThrottleFloor) begin
      tnew = qtpm_pkg::ThrottleFloor;
    end
    quiet_d = quiet_q;
    for (int k = 0; k < NM; k++) begin
      base_d[k] = base_q[k];
    end
    if (s1_cmd_q) begin
      quiet_d = '0;
      for (int k = 0; k < NM; k++) begin
        base_d[k] = $signed({2'b00, s1_motor_q[k]});
      end
    end else if (quiet_q < loss_limit_q) begin
      quiet_d = quiet_q + 16'd1;
    end else begin
      for (int k = 0; k < NM; k++) begin
        base_d[k] = tnew[9:0];
      end
    end
  end

  logic s2_load;
  assign s2_load = s2_en && s1_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leak_x_q <= '0;
      leak_y_q <= '0;
      prev_x_q <= '0;
      prev_y_q <= '0;
      quiet_q  <= '0;
      for (int k = 0; k < NM; k++) begin
        base_q[k] <= qtpm_pkg::ThrottleReset;
      end
    end else if (s2_load) begin
      leak_x_q <= leak_x_d;
      leak_y_q <= leak_y_d;
      prev_x_q <= err_x;
      prev_y_q <= err_y;
      quiet_q  <= quiet_d;
      for (int k = 0; k < NM; k++) begin
        base_q[k] <= base_d[k];
      end
    end
  end

  qtpm_pkg::err_t      s2_err_x_q, s2_err_y_q;
  qtpm_pkg::leak_t     s2_leak_x_q, s2_leak_y_q;
  qtpm_pkg::deriv_t    s2_der_x_q, s2_der_y_q;
  qtpm_pkg::throttle_t s2_base_q [NM];

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_err_x_q  <= err_x;
      s2_err_y_q  <= err_y;
      s2_leak_x_q <= leak_x_d;
      s2_leak_y_q <= leak_y_d;
      s2_der_x_q  <= 15'(err_x) - 15'(prev_x_q);
      s2_der_y_q  <= 15'(err_y) - 15'(prev_y_q);
      for (int k = 0; k < NM; k++) begin
        s2_base_q[k] <= base_d[k];
      end
    end
  end

  // ---------------- stage 3: gain products ----------------
  logic signed [16:0] gp, gi, gd;
  assign gp = $signed({1'b0, gain_p_q});
  assign gi = $signed({1'b0, gain_i_q});
  assign gd = $signed({1'b0, gain_d_q});

  logic signed [30:0]  s3_pp_x_q, s3_pp_y_q;
  logic signed [32:0]  s3_pi_x_q, s3_pi_y_q;
  logic signed [31:0]  s3_pd_x_q, s3_pd_y_q;
  qtpm_pkg::throttle_t s3_base_q [NM];

  always_ff @(posedge clk_i) begin
    if (s3_en && s2_v_q) begin
      s3_pp_x_q <= 31'(gp) * 31'(s2_err_x_q);
      s3_pp_y_q <= 31'(gp) * 31'(s2_err_y_q);
      s3_pi_x_q <= 33'(gi) * 33'(s2_leak_x_q);
      s3_pi_y_q <= 33'(gi) * 33'(s2_leak_y_q);
      s3_pd_x_q <= 32'(gd) * 32'(s2_der_x_q);
      s3_pd_y_q <= 32'(gd) * 32'(s2_der_y_q);
      for (int k = 0; k < NM; k++) begin
        s3_base_q[k] <= s2_base_q[k];
      end
    end
  end

  // ---------------- stage 4: axis terms, Q18.16 ----------------
  logic signed [33:0]  s4_tx_q, s4_ty_q;
  qtpm_pkg::throttle_t s4_base_q [NM];

  always_ff @(posedge clk_i) begin
    if (s4_en && s3_v_q) begin
      s4_tx_q <= 34'(s3_pp_x_q) + 34'(s3_pi_x_q) + 34'(s3_pd_x_q);
      s4_ty_q <= 34'(s3_pp_y_q) + 34'(s3_pi_y_q) + 34'(s3_pd_y_q);
      for (int k = 0; k < NM; k++) begin
        s4_base_q[k] <= s3_base_q[k];
      end
    end
  end

  // ---------------- output: mix, truncate toward zero, saturate ----------------
  logic signed [34:0] mix  [NM];
  logic signed [34:0] bias [NM];
  logic signed [18:0] corr [NM];
  logic signed [19:0] sum  [NM];
  logic [7:0]         drive_d [NM];
  logic [7:0]         drive_q [NM];

  always_comb begin
    for (int k = 0; k < NM; k++) begin
      mix[k] = (qtpm_pkg::SignXNeg[k] ? -35'(s4_tx_q) : 35'(s4_tx_q))
             + (qtpm_pkg::SignYNeg[k] ? -35'(s4_ty_q) : 35'(s4_ty_q));
      bias[k] = mix[k] + (mix[k][34] ? 35'sd65535 : 35'sd0);
      corr[k] = bias[k][34:16];
      sum[k]  = 20'(s4_base_q[k]) + 20'(corr[k]);
      if (sum[k][19]) begin
        drive_d[k] = 8'd0;
      end else if (sum[k] > qtpm_pkg::DriveMax) begin
        drive_d[k] = qtpm_pkg::DriveMax[7:0];
      end else begin
        drive_d[k] = sum[k][7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && s4_v_q) begin
      for (int k = 0; k < NM; k++) begin
        drive_q[k] <= drive_d[k];
      end
    end
  end

  assign drive_a_o = drive_q[0];
  assign drive_b_o = drive_q[1];
  assign drive_c_o = drive_q[2];
  assign drive_d_o = drive_q[3];

endmodule
